// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker in osm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define OSM_ASSERT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("osm_checker: property failed");

// Clocked property that must hold in reset as well.
`define OSM_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("osm_checker: property failed");

`endif

// ===== rtl/osm_pkg.sv =====
// Types, widths and register codes for the obstacle steering mixer.
package osm_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int DIST_FIELD   = 20;
	localparam int DIST_BITS    = 20;
	localparam int DIST_USE     = (DIST_BITS < DIST_FIELD) ? DIST_BITS : DIST_FIELD;
	localparam int W_BITS       = 8;
	localparam int FRAC_BITS    = 4;
	localparam int SPEED_W      = 16;
	localparam int DRIVE_W      = 31;

	// signed weight x distance
	localparam int PROD_W  = DIST_BITS + W_BITS;
	localparam int PAIR_W  = PROD_W + 1;
	// eight products plus 16*(d2+d5), with sign
	localparam int ACC_W   = PROD_W + 4;
	localparam int SUM_W   = ACC_W - FRAC_BITS;
	localparam int MAG_W   = SUM_W - 1;
	localparam int NUM_W   = MAG_W + SPEED_W;

	localparam int DIV_BPS    = 4;
	localparam int QUOT_W     = ((NUM_W + DIV_BPS - 1) / DIV_BPS) * DIV_BPS;
	localparam int DIV_STAGES = QUOT_W / DIV_BPS;

	localparam int IN_DATA_W  = ((SENSOR_COUNT * DIST_FIELD + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * DRIVE_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_WEIGHTS   = 3'd0,
		REG_RIGHT_WEIGHTS  = 3'd1,
		REG_NEAR_THRESHOLD = 3'd2,
		REG_FULL_SPEED     = 3'd3,
		REG_MIN_SPEED      = 3'd4
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] LEFT_WEIGHTS_RST  = 64'h001020F810F8F800;
	localparam logic [CFG_DATA_W-1:0] RIGHT_WEIGHTS_RST = 64'h00F8F810F8201000;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] left_weights;
		logic [CFG_DATA_W-1:0] right_weights;
		logic [DIST_BITS-1:0]  near_threshold;
		logic [SPEED_W-1:0]    full_speed;
		logic [SPEED_W-1:0]    min_speed;
	} cfg_t;

	typedef struct packed {
		logic near;
		logic zero;
		logic neg_l;
		logic neg_r;
	} flags_t;

	typedef struct packed {
		logic             valid;
		flags_t           flags;
		logic [NUM_W-1:0] num_l;
		logic [NUM_W-1:0] num_r;
		logic [MAG_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic              valid;
		flags_t            flags;
		logic [QUOT_W-1:0] quot_l;
		logic [QUOT_W-1:0] quot_r;
	} div_out_t;

endpackage

// ===== rtl/obstacle_steering_mixer_core.sv =====
// Pipeline: an input transfer passes 6 front stages, 11 divider stages and the output
// register before its result is valid. Throughput: one sensor set per cycle; the whole pipeline
// advances whenever the output register is empty or its result is taken, so a stalled
// output holds every stage. The divider yields four quotient bits per stage per lane.
// Reset (arst_n low, asynchronous): all valid bits clear, configuration registers take their defaults.
module obstacle_steering_mixer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// dist_0 .. dist_7, 20 bits each, dist_0 lowest
	input  logic [osm_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// left_drive [30:0], right_drive [61:31], zero fill [63:62]
	output logic [osm_pkg::OUT_DATA_W-1:0]    m_tdata,
	// obstacle_near [0], drive_updated [1]
	output logic [1:0]                        m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [osm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [osm_pkg::CFG_DATA_W-1:0] left_weights_q;
	logic [osm_pkg::CFG_DATA_W-1:0] right_weights_q;
	logic [osm_pkg::DIST_BITS-1:0]  near_threshold_q;
	logic [osm_pkg::SPEED_W-1:0]    full_speed_q;
	logic [osm_pkg::SPEED_W-1:0]    min_speed_q;
	osm_pkg::cfg_t                  cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_weights_q   <= osm_pkg::LEFT_WEIGHTS_RST;
			right_weights_q  <= osm_pkg::RIGHT_WEIGHTS_RST;
			near_threshold_q <= '0;
			full_speed_q     <= '0;
			min_speed_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				osm_pkg::REG_LEFT_WEIGHTS:   left_weights_q   <= cfg_data;
				osm_pkg::REG_RIGHT_WEIGHTS:  right_weights_q  <= cfg_data;
				osm_pkg::REG_NEAR_THRESHOLD: near_threshold_q <= cfg_data[osm_pkg::DIST_BITS-1:0];
				osm_pkg::REG_FULL_SPEED:     full_speed_q     <= cfg_data[osm_pkg::SPEED_W-1:0];
				osm_pkg::REG_MIN_SPEED:      min_speed_q      <= cfg_data[osm_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.left_weights   = left_weights_q;
		cfg.right_weights  = right_weights_q;
		cfg.near_threshold = near_threshold_q;
		cfg.full_speed     = full_speed_q;
		cfg.min_speed      = min_speed_q;
	end

	// global advance
	logic en;
	logic m_valid_q;
	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;

	osm_pkg::div_in_t  front_out;
	osm_pkg::div_out_t div_out;

	osm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.cfg      (cfg),
		.out      (front_out)
	);

	osm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in     (front_out),
		.out    (div_out)
	);

	// final drive selection
	function automatic logic [osm_pkg::DRIVE_W-1:0] scale_drive(
		input logic [osm_pkg::QUOT_W-1:0]  quot,
		input logic                        neg,
		input logic [osm_pkg::SPEED_W-1:0] min_speed
	);
		logic [osm_pkg::DRIVE_W-1:0] qs;
		logic [osm_pkg::DRIVE_W-1:0] mn;
		mn = osm_pkg::DRIVE_W'(min_speed);
		if (|quot[osm_pkg::QUOT_W-1:osm_pkg::DRIVE_W])
			qs = '1;
		else
			qs = quot[osm_pkg::DRIVE_W-1:0];
		if (neg || qs < mn)
			qs = mn;
		return qs;
	endfunction

	logic [osm_pkg::DRIVE_W-1:0] left_c;
	logic [osm_pkg::DRIVE_W-1:0] right_c;
	logic                        near_c;
	logic                        upd_c;

	always_comb begin
		if (!div_out.flags.near) begin
			left_c  = osm_pkg::DRIVE_W'(full_speed_q);
			right_c = osm_pkg::DRIVE_W'(full_speed_q);
			near_c  = 1'b0;
			upd_c   = 1'b1;
		end else if (div_out.flags.zero) begin
			left_c  = '0;
			right_c = '0;
			near_c  = 1'b1;
			upd_c   = 1'b0;
		end else begin
			left_c  = scale_drive(div_out.quot_l, div_out.flags.neg_l, min_speed_q);
			right_c = scale_drive(div_out.quot_r, div_out.flags.neg_r, min_speed_q);
			near_c  = 1'b1;
			upd_c   = 1'b1;
		end
	end

	// output register
	logic [osm_pkg::OUT_DATA_W-1:0] m_data_q;
	logic [1:0]                     m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (en)
			m_valid_q <= div_out.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= osm_pkg::OUT_DATA_W'({right_c, left_c});
			m_user_q <= {upd_c, near_c};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

// ===== rtl/osm_front.sv =====
// Front pipeline: near detect, weighted sums, truncation, max select, scale by full speed.
module osm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [osm_pkg::IN_DATA_W-1:0]    in_data,
	input  osm_pkg::cfg_t                    cfg,
	output osm_pkg::div_in_t                 out
);

	localparam int N = osm_pkg::SENSOR_COUNT;

	// stage 1: products and near flag
	logic                                   valid_s1;
	logic                                   near_s1;
	logic signed [osm_pkg::PROD_W-1:0]      pl_s1 [N];
	logic signed [osm_pkg::PROD_W-1:0]      pr_s1 [N];
	logic [osm_pkg::DIST_BITS:0]            fr_s1;

	logic [osm_pkg::DIST_BITS-1:0]          d [N];
	logic signed [osm_pkg::PROD_W:0]        ml [N];
	logic signed [osm_pkg::PROD_W:0]        mr [N];
	logic                                   near;

	always_comb begin
		near = 1'b0;
		for (int k = 0; k < N; k++) begin
			d[k] = osm_pkg::DIST_BITS'(in_data[k*osm_pkg::DIST_FIELD +: osm_pkg::DIST_USE]);
			if (d[k] <= cfg.near_threshold)
				near = 1'b1;
			ml[k] = $signed({1'b0, d[k]})
				* $signed(cfg.left_weights[k*osm_pkg::W_BITS +: osm_pkg::W_BITS]);
			mr[k] = $signed({1'b0, d[k]})
				* $signed(cfg.right_weights[k*osm_pkg::W_BITS +: osm_pkg::W_BITS]);
		end
	end

	// stage 2: pair sums
	logic                                   valid_s2;
	logic                                   near_s2;
	logic signed [osm_pkg::PAIR_W-1:0]      pl_s2 [N/2];
	logic signed [osm_pkg::PAIR_W-1:0]      pr_s2 [N/2];
	logic [osm_pkg::DIST_BITS:0]            fr_s2;

	// stage 3: full accumulators (x16)
	logic                                   valid_s3;
	logic                                   near_s3;
	logic signed [osm_pkg::ACC_W-1:0]       al_s3;
	logic signed [osm_pkg::ACC_W-1:0]       ar_s3;
	logic signed [osm_pkg::ACC_W-1:0]       al;
	logic signed [osm_pkg::ACC_W-1:0]       ar;
	logic signed [osm_pkg::ACC_W-1:0]       front16;

	always_comb begin
		front16 = osm_pkg::ACC_W'($signed({1'b0, fr_s2, {osm_pkg::FRAC_BITS{1'b0}}}));
		al = front16;
		ar = front16;
		for (int j = 0; j < N/2; j++) begin
			al = al + osm_pkg::ACC_W'(pl_s2[j]);
			ar = ar + osm_pkg::ACC_W'(pr_s2[j]);
		end
	end

	// stage 4: divide by 16 toward zero
	logic                                   valid_s4;
	logic                                   near_s4;
	logic signed [osm_pkg::SUM_W-1:0]       sl_s4;
	logic signed [osm_pkg::SUM_W-1:0]       sr_s4;
	logic signed [osm_pkg::ACC_W-1:0]       adj_l;
	logic signed [osm_pkg::ACC_W-1:0]       adj_r;

	always_comb begin
		adj_l = al_s3 + $signed({{(osm_pkg::ACC_W-osm_pkg::FRAC_BITS){1'b0}},
			{osm_pkg::FRAC_BITS{al_s3[osm_pkg::ACC_W-1]}}});
		adj_r = ar_s3 + $signed({{(osm_pkg::ACC_W-osm_pkg::FRAC_BITS){1'b0}},
			{osm_pkg::FRAC_BITS{ar_s3[osm_pkg::ACC_W-1]}}});
	end

	// stage 5: zero check, larger sum, magnitudes and quotient signs
	logic                                   valid_s5;
	osm_pkg::flags_t                        flags_s5;
	logic [osm_pkg::MAG_W-1:0]              mag_l_s5;
	logic [osm_pkg::MAG_W-1:0]              mag_r_s5;
	logic [osm_pkg::MAG_W-1:0]              mag_m_s5;
	logic signed [osm_pkg::SUM_W-1:0]       smax;
	logic signed [osm_pkg::SUM_W-1:0]       neg_sl;
	logic signed [osm_pkg::SUM_W-1:0]       neg_sr;
	logic signed [osm_pkg::SUM_W-1:0]       neg_sm;
	osm_pkg::flags_t                        flags_c;

	always_comb begin
		smax   = (sr_s4 > sl_s4) ? sr_s4 : sl_s4;
		neg_sl = -sl_s4;
		neg_sr = -sr_s4;
		neg_sm = -smax;
		flags_c.near  = near_s4;
		flags_c.zero  = (sl_s4 == '0) || (sr_s4 == '0);
		flags_c.neg_l = sl_s4[osm_pkg::SUM_W-1] ^ smax[osm_pkg::SUM_W-1];
		flags_c.neg_r = sr_s4[osm_pkg::SUM_W-1] ^ smax[osm_pkg::SUM_W-1];
	end

	// stage 6: numerators scaled by full speed
	logic                                   valid_s6;
	osm_pkg::flags_t                        flags_s6;
	logic [osm_pkg::NUM_W-1:0]              num_l_s6;
	logic [osm_pkg::NUM_W-1:0]              num_r_s6;
	logic [osm_pkg::MAG_W-1:0]              den_s6;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			near_s1 <= near;
			fr_s1   <= {1'b0, d[2]} + {1'b0, d[5]};
			for (int k = 0; k < N; k++) begin
				pl_s1[k] <= ml[k][osm_pkg::PROD_W-1:0];
				pr_s1[k] <= mr[k][osm_pkg::PROD_W-1:0];
			end

			near_s2 <= near_s1;
			fr_s2   <= fr_s1;
			for (int j = 0; j < N/2; j++) begin
				pl_s2[j] <= osm_pkg::PAIR_W'(pl_s1[2*j]) + osm_pkg::PAIR_W'(pl_s1[2*j+1]);
				pr_s2[j] <= osm_pkg::PAIR_W'(pr_s1[2*j]) + osm_pkg::PAIR_W'(pr_s1[2*j+1]);
			end

			near_s3 <= near_s2;
			al_s3   <= al;
			ar_s3   <= ar;

			near_s4 <= near_s3;
			sl_s4   <= adj_l[osm_pkg::ACC_W-1:osm_pkg::FRAC_BITS];
			sr_s4   <= adj_r[osm_pkg::ACC_W-1:osm_pkg::FRAC_BITS];

			flags_s5 <= flags_c;
			mag_l_s5 <= sl_s4[osm_pkg::SUM_W-1] ? neg_sl[osm_pkg::MAG_W-1:0]
			                                     : sl_s4[osm_pkg::MAG_W-1:0];
			mag_r_s5 <= sr_s4[osm_pkg::SUM_W-1] ? neg_sr[osm_pkg::MAG_W-1:0]
			                                     : sr_s4[osm_pkg::MAG_W-1:0];
			mag_m_s5 <= smax[osm_pkg::SUM_W-1] ? neg_sm[osm_pkg::MAG_W-1:0]
			                                    : smax[osm_pkg::MAG_W-1:0];

			flags_s6 <= flags_s5;
			num_l_s6 <= mag_l_s5 * cfg.full_speed;
			num_r_s6 <= mag_r_s5 * cfg.full_speed;
			den_s6   <= mag_m_s5;
		end
	end

	assign out.valid = valid_s6;
	assign out.flags = flags_s6;
	assign out.num_l = num_l_s6;
	assign out.num_r = num_r_s6;
	assign out.den   = den_s6;

endmodule

// ===== rtl/osm_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, four quotient bits per stage.
module osm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  osm_pkg::div_in_t   in,
	output osm_pkg::div_out_t  out
);

	localparam int NS = osm_pkg::DIV_STAGES;

	typedef struct packed {
		logic [osm_pkg::MAG_W-1:0]  rem;
		logic [osm_pkg::QUOT_W-1:0] dq;
	} step_t;

	// dq shifts dividend bits out at the top and quotient bits in at the bottom
	function automatic step_t div_step(
		input logic [osm_pkg::MAG_W-1:0]  rem,
		input logic [osm_pkg::QUOT_W-1:0] dq,
		input logic [osm_pkg::MAG_W-1:0]  den
	);
		logic [osm_pkg::MAG_W:0]    trial;
		logic [osm_pkg::MAG_W-1:0]  r;
		logic [osm_pkg::QUOT_W-1:0] q;
		step_t                      res;
		r = rem;
		q = dq;
		for (int b = 0; b < osm_pkg::DIV_BPS; b++) begin
			trial = {r, q[osm_pkg::QUOT_W-1]};
			q = {q[osm_pkg::QUOT_W-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				trial = trial - {1'b0, den};
				q[0] = 1'b1;
			end
			r = trial[osm_pkg::MAG_W-1:0];
		end
		res.rem = r;
		res.dq  = q;
		return res;
	endfunction

	logic                        valid_s [NS];
	osm_pkg::flags_t             flags_s [NS];
	logic [osm_pkg::MAG_W-1:0]   den_s   [NS];
	step_t                       lane_l_s [NS];
	step_t                       lane_r_s [NS];

	step_t                       nxt_l [NS];
	step_t                       nxt_r [NS];

	always_comb begin
		nxt_l[0] = div_step('0, osm_pkg::QUOT_W'(in.num_l), in.den);
		nxt_r[0] = div_step('0, osm_pkg::QUOT_W'(in.num_r), in.den);
		for (int i = 1; i < NS; i++) begin
			nxt_l[i] = div_step(lane_l_s[i-1].rem, lane_l_s[i-1].dq, den_s[i-1]);
			nxt_r[i] = div_step(lane_r_s[i-1].rem, lane_r_s[i-1].dq, den_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++)
				valid_s[i] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in.valid;
			for (int i = 1; i < NS; i++)
				valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s[0] <= in.flags;
			den_s[0]   <= in.den;
			for (int i = 1; i < NS; i++) begin
				flags_s[i] <= flags_s[i-1];
				den_s[i]   <= den_s[i-1];
			end
			for (int i = 0; i < NS; i++) begin
				lane_l_s[i] <= nxt_l[i];
				lane_r_s[i] <= nxt_r[i];
			end
		end
	end

	assign out.valid  = valid_s[NS-1];
	assign out.flags  = flags_s[NS-1];
	assign out.quot_l = lane_l_s[NS-1].dq;
	assign out.quot_r = lane_r_s[NS-1].dq;

endmodule

// ===== rtl/osm_checker.sv =====
// Port-level checks for the steering mixer, bound to the top level.
`include "assert_macros.svh"

module osm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [osm_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	// a result that is not an update carries zero drives
	`OSM_ASSERT(a_stale_zero, clk, arst_n, m_tvalid && !m_tuser[1] |-> m_tdata == '0)

	// no obstacle always means fresh drives
	`OSM_ASSERT(a_clear_updates, clk, arst_n, m_tvalid && !m_tuser[0] |-> m_tuser[1])

	// a held result stays put until transfer
	`OSM_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a stalled output stalls the input side too
	`OSM_ASSERT_ALWAYS(a_backpressure, clk, m_tvalid && !m_tready |-> !s_tready)

endmodule

bind obstacle_steering_mixer_core osm_checker u_osm_checker (.*);

// ===== sim/steering_drive_check.sv =====
// Checker for the steering mixer: tracks register writes, predicts each drive result, compares.
module steering_drive_check
	import osm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef logic [SENSOR_COUNT-1:0][DIST_FIELD-1:0] dist_set_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] left_drive;
		logic [DRIVE_W-1:0] right_drive;
		logic               obstacle_near;
		logic               drive_updated;
	} drive_result_t;

	localparam longint DRIVE_MAX    = (longint'(1) << DRIVE_W) - 1;
	localparam longint Q_ONE        = longint'(1) << FRAC_BITS;
	localparam int     REPORT_LIMIT = 10;

	logic [CFG_DATA_W-1:0] left_taps;
	logic [CFG_DATA_W-1:0] right_taps;
	logic [DIST_BITS-1:0]  near_limit;
	logic [SPEED_W-1:0]    full_speed;
	logic [SPEED_W-1:0]    min_speed;

	drive_result_t pending_drives[$];
	drive_result_t want;
	drive_result_t seen;
	int            errors;

	assign mismatches = errors;

	// Weighted sum in Q4.4 with the two front sensors added at unit weight,
	// then truncated toward zero.
	function automatic longint tap_sum(logic [CFG_DATA_W-1:0] taps, dist_set_t dists);
		longint           acc;
		longint           d;
		logic signed [7:0] w;
		acc = 0;
		for (int k = 0; k < SENSOR_COUNT; k++) begin
			d = longint'(dists[k][DIST_USE-1:0]);
			w = taps[W_BITS*k +: W_BITS];
			acc += longint'(w) * d;
			if (k == 2 || k == 5)
				acc += Q_ONE * d;
		end
		return acc / Q_ONE;
	endfunction

	function automatic logic [DRIVE_W-1:0] scale_drive(longint sum, longint peak);
		longint q;
		q = (sum * longint'(full_speed)) / peak;
		if (q > DRIVE_MAX)
			q = DRIVE_MAX;
		if (q < longint'(min_speed))
			q = longint'(min_speed);
		return q[DRIVE_W-1:0];
	endfunction

	function automatic drive_result_t predict_drives(dist_set_t dists);
		drive_result_t r;
		logic          near;
		longint        lsum;
		longint        rsum;
		longint        peak;
		near = 1'b0;
		for (int k = 0; k < SENSOR_COUNT; k++)
			if (dists[k][DIST_USE-1:0] <= near_limit)
				near = 1'b1;
		r.obstacle_near = near;
		r.drive_updated = 1'b1;
		r.left_drive    = '0;
		r.right_drive   = '0;
		if (!near) begin
			r.left_drive  = DRIVE_W'(full_speed);
			r.right_drive = DRIVE_W'(full_speed);
			return r;
		end
		lsum = tap_sum(left_taps, dists);
		rsum = tap_sum(right_taps, dists);
		if (lsum == 0 || rsum == 0) begin
			r.drive_updated = 1'b0;
			return r;
		end
		// larger sum may be negative; the division is signed either way
		peak = (rsum > lsum) ? rsum : lsum;
		r.left_drive  = scale_drive(lsum, peak);
		r.right_drive = scale_drive(rsum, peak);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_taps   <= LEFT_WEIGHTS_RST;
			right_taps  <= RIGHT_WEIGHTS_RST;
			near_limit  <= '0;
			full_speed  <= '0;
			min_speed   <= '0;
			pending_drives.delete();
			errors      = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.left_drive    = m_tdata[DRIVE_W-1:0];
				seen.right_drive   = m_tdata[2*DRIVE_W-1:DRIVE_W];
				seen.obstacle_near = m_tuser[0];
				seen.drive_updated = m_tuser[1];
				if (pending_drives.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: drive result with none pending: data %h user %b",
							$time, m_tdata, m_tuser);
				end else begin
					want = pending_drives.pop_front();
					if (seen.left_drive != want.left_drive
							|| seen.right_drive != want.right_drive
							|| seen.obstacle_near != want.obstacle_near
							|| seen.drive_updated != want.drive_updated
							|| m_tdata[OUT_DATA_W-1:2*DRIVE_W] != '0) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display({"%0t: drive mismatch (expected/actual): left %0d/%0d ",
								"right %0d/%0d near %b/%b updated %b/%b fill %b"},
								$time, want.left_drive, seen.left_drive,
								want.right_drive, seen.right_drive,
								want.obstacle_near, seen.obstacle_near,
								want.drive_updated, seen.drive_updated,
								m_tdata[OUT_DATA_W-1:2*DRIVE_W]);
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_drives.push_back(predict_drives(s_tdata));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEFT_WEIGHTS:   left_taps  <= cfg_data;
					REG_RIGHT_WEIGHTS:  right_taps <= cfg_data;
					REG_NEAR_THRESHOLD: near_limit <= cfg_data[DIST_BITS-1:0];
					REG_FULL_SPEED:     full_speed <= cfg_data[SPEED_W-1:0];
					REG_MIN_SPEED:      min_speed  <= cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			outstanding <= pending_drives.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Bench top for the steering mixer: clock, reset, register setup, sensor sets and verdict.
module testbench;
	import osm_pkg::*;

	typedef logic [SENSOR_COUNT-1:0][DIST_FIELD-1:0] dist_set_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 24;
	localparam int PHASES      = 7;
	localparam int PHASE_SETS  = 230;
	localparam logic [DIST_FIELD-1:0] DIST_TOP    = '1;
	localparam logic [CFG_IDX_W-1:0]  SPARE_INDEX = CFG_IDX_W'(REG_MIN_SPEED) + 1'b1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                    mismatches;
	int                    outstanding;
	int                    idle_cycles;
	int                    src_gap_pct;
	bit                    quiet;
	logic [DIST_FIELD-1:0] cur_threshold;

	obstacle_steering_mixer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	steering_drive_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic dist_set_t uniform_set(logic [DIST_FIELD-1:0] d);
		return {SENSOR_COUNT{d}};
	endfunction

	// Mix of silent sensors, the threshold edges, tiny values and full-range values.
	function automatic logic [DIST_FIELD-1:0] rand_dist();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return DIST_TOP;
			2: return cur_threshold;
			3: return cur_threshold + 1'b1;
			4, 5: return DIST_FIELD'($urandom_range(0, 15));
			6: return DIST_FIELD'($urandom_range(0, cur_threshold));
			default: return DIST_FIELD'($urandom);
		endcase
	endfunction

	function automatic dist_set_t rand_set();
		dist_set_t             set;
		logic [DIST_FIELD-1:0] d;
		case ($urandom_range(0, 19))
			0: set = '0;
			1: set = uniform_set(DIST_TOP);
			2: begin
				d = rand_dist();
				set = uniform_set(d);
			end
			default: begin
				for (int k = 0; k < SENSOR_COUNT; k++)
					set[k] = rand_dist();
			end
		endcase
		return set;
	endfunction

	task automatic send_set(input dist_set_t set);
		if (!quiet && $urandom_range(1, 100) <= src_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= set;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Unused bits above each narrow register are filled with noise; the block drops them.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] left_w, right_w,
			input logic [DIST_FIELD-1:0] thr, input logic [SPEED_W-1:0] fast, slow);
		logic [CFG_DATA_W-1:0] word;
		write_reg(REG_LEFT_WEIGHTS, left_w);
		write_reg(REG_RIGHT_WEIGHTS, right_w);
		word = rand_word();
		word[DIST_FIELD-1:0] = thr;
		write_reg(REG_NEAR_THRESHOLD, word);
		write_reg(SPARE_INDEX + CFG_IDX_W'($urandom_range(0, 2)), rand_word());
		word = rand_word();
		word[SPEED_W-1:0] = fast;
		write_reg(REG_FULL_SPEED, word);
		word = rand_word();
		word[SPEED_W-1:0] = slow;
		write_reg(REG_MIN_SPEED, word);
		cfg_valid <= 1'b0;
		cur_threshold = thr;
	endtask

	task automatic program_phase(input int p);
		logic [SPEED_W-1:0]    fs;
		logic [DIST_FIELD-1:0] thr;
		fs  = SPEED_W'($urandom);
		thr = ($urandom_range(0, 1) != 0) ? DIST_FIELD'($urandom)
			: DIST_FIELD'($urandom_range(0, 2000));
		case (p)
			0: program_regs(LEFT_WEIGHTS_RST, RIGHT_WEIGHTS_RST, thr, fs,
				SPEED_W'($urandom_range(0, 200)));
			1: program_regs(64'h8080808080808080, 64'h7F7F7F7F7F7F7F7F, '1, '1, '1);
			2: program_regs('0, '0, '0, '0, '0);
			default: program_regs(rand_word(), rand_word(), thr, fs,
				SPEED_W'($urandom_range(0, fs)));
		endcase
	endtask

	// Stop feeding and let every pending result come out before touching registers.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side: stall bursts, with the stall rate changing from stretch to stretch
	initial begin
		int stretch;
		int stall_pct;
		m_tready <= 1'b0;
		stretch   = 0;
		stall_pct = 0;
		@(posedge arst_n);
		forever begin
			if (stretch == 0) begin
				stretch   = $urandom_range(100, 300);
				stall_pct = pick_pct();
			end
			stretch--;
			if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= QUIET_LIMIT) begin
			$display("FAIL obstacle_steering_mixer_core");
			$finish;
		end
	end

	initial begin
		dist_set_t set;
		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_LEFT_WEIGHTS;
		cfg_data      <= '0;
		quiet         = 1'b0;
		src_gap_pct   = 10;
		cur_threshold = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: threshold and full speed both zero
		send_set('0);
		send_set(uniform_set(DIST_TOP));
		set = uniform_set(20'd300000);
		set[4] = '0;
		send_set(set);
		drain();

		program_regs(LEFT_WEIGHTS_RST, RIGHT_WEIGHTS_RST, 20'd100, 16'hFFFF, 16'd7);
		send_set(uniform_set(DIST_TOP));
		send_set(uniform_set(20'd100));
		send_set(uniform_set(20'd101));
		set = uniform_set(20'd900000);
		set[6] = '0;
		send_set(set);
		for (int k = 1; k < 4; k++)
			send_set(uniform_set(DIST_FIELD'(k)));
		set = uniform_set(20'd50);
		set[2] = 20'd5000;
		send_set(set);
		drain();

		// right sum of exactly -1 against a hugely negative left sum: left saturates
		program_regs(64'h8080808080808080, 64'h0000EF0000F00000, '0, 16'hFFFF, '0);
		set = uniform_set(20'd1000000);
		set[0] = '0;
		set[2] = 20'd5000;
		set[5] = 20'd16;
		send_set(set);
		set[5] = '0;
		send_set(set);
		send_set(uniform_set(DIST_TOP));
		drain();

		// left sum positive, right negative: right drive falls back to min speed
		program_regs(64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080, '1, 16'hFFFF, 16'd100);
		send_set(uniform_set(DIST_TOP));
		send_set('0);
		send_set(rand_set());
		send_set(rand_set());

		for (int p = 0; p < PHASES; p++) begin
			drain();
			program_phase(p);
			src_gap_pct = pick_pct();
			quiet = (p == PHASES - 1);
			repeat (PHASE_SETS) send_set(rand_set());
		end
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("PASS obstacle_steering_mixer_core");
		else
			$display("FAIL obstacle_steering_mixer_core");
		$finish;
	end

endmodule
